// ===== design/touch_tap_slide_classifier_assert.svh =====
// Assertion macros used by the touch tap and slide classifier top level.
`ifndef TOUCH_TAP_SLIDE_CLASSIFIER_ASSERT_SVH
`define TOUCH_TAP_SLIDE_CLASSIFIER_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define TTS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("touch classifier: invariant violated");

// Checks that a condition in one cycle is followed by another in the next cycle.
`define TTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("touch classifier: sequence violated");

`endif

// ===== design/tts_pkg.sv =====
// Types, constants and helper functions of the touch tap and slide classifier.
package tts_pkg;

  // Coordinate bits that take part in tracking; the port fields stay 15 bits wide.
  localparam int unsigned CoordWidth = 15;
  localparam int unsigned PortCoordW = 15;
  localparam int unsigned DiffW      = 16;
  localparam int unsigned MagW       = CoordWidth + 1;

  localparam int unsigned DataInW  = 40;
  localparam int unsigned DataOutW = 96;
  localparam int unsigned CountW   = 4;
  localparam int unsigned XLsb     = 4;
  localparam int unsigned YLsb     = XLsb + PortCoordW;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgSlideRange = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxPoints  = 2'd1;

  localparam logic [7:0] SlideRangeRst = 8'd6;
  localparam logic [3:0] MaxPointsRst  = 4'd5;

  localparam logic [2:0] EvNone     = 3'd0;
  localparam logic [2:0] EvDown     = 3'd1;
  localparam logic [2:0] EvUp       = 3'd2;
  localparam logic [2:0] EvSlide    = 3'd3;
  localparam logic [2:0] EvSlideEnd = 3'd4;

  typedef enum logic [4:0] {
    GestNone     = 5'b00001,
    GestDown     = 5'b00010,
    GestUp       = 5'b00100,
    GestSlide    = 5'b01000,
    GestSlideEnd = 5'b10000
  } gesture_e;

  typedef struct packed {
    logic [7:0] slide_thresh;
    logic [3:0] max_points;
  } tts_cfg_t;

  typedef struct packed {
    logic                  ready;
    logic [CountW-1:0]     count;
    logic [CoordWidth-1:0] x;
    logic [CoordWidth-1:0] y;
  } tts_item_t;

  typedef struct packed {
    gesture_e              gesture;
    logic [CoordWidth-1:0] cur_x;
    logic [CoordWidth-1:0] cur_y;
    logic [CoordWidth-1:0] begin_x;
    logic [CoordWidth-1:0] begin_y;
    logic [DiffW-1:0]      diff_x;
    logic [DiffW-1:0]      diff_y;
  } tts_state_t;

  function automatic logic [2:0] event_code(gesture_e g);
    logic [2:0] code;
    unique case (g)
      GestNone:     code = EvNone;
      GestDown:     code = EvDown;
      GestUp:       code = EvUp;
      GestSlide:    code = EvSlide;
      GestSlideEnd: code = EvSlideEnd;
      default:      code = EvNone;
    endcase
    return code;
  endfunction

endpackage

// ===== design/tts_step.sv =====
// Next-state logic of the touch classifier for one poll.
module tts_step (
  input  tts_pkg::tts_state_t state_i,
  input  tts_pkg::tts_item_t  item_i,
  input  tts_pkg::tts_cfg_t   cfg_i,
  output tts_pkg::tts_state_t state_o
);
  import tts_pkg::*;

  logic signed [CoordWidth:0] dx, dy;
  logic        [CoordWidth:0] mag_x, mag_y;
  logic                       count_ok;
  logic                       far;

  assign dx = $signed({1'b0, item_i.x}) - $signed({1'b0, state_i.cur_x});
  assign dy = $signed({1'b0, item_i.y}) - $signed({1'b0, state_i.cur_y});
  assign mag_x = dx[CoordWidth] ? MagW'(-dx) : MagW'(dx);
  assign mag_y = dy[CoordWidth] ? MagW'(-dy) : MagW'(dy);
  assign far = (mag_x >= MagW'(cfg_i.slide_thresh)) || (mag_y >= MagW'(cfg_i.slide_thresh));
  assign count_ok = (item_i.count != '0) && (item_i.count <= cfg_i.max_points);

  always_comb begin
    state_o = state_i;
    if (item_i.ready) begin
      if (count_ok) begin
        unique case (state_i.gesture) inside
          GestNone, GestUp, GestSlideEnd: begin
            state_o.gesture = GestDown;
            state_o.cur_x   = item_i.x;
            state_o.cur_y   = item_i.y;
            state_o.begin_x = item_i.x;
            state_o.begin_y = item_i.y;
          end
          GestDown, GestSlide: begin
            state_o.diff_x = DiffW'(dx);
            state_o.diff_y = DiffW'(dy);
            if ((state_i.gesture == GestSlide) || far) begin
              state_o.gesture = GestSlide;
              state_o.cur_x   = item_i.x;
              state_o.cur_y   = item_i.y;
            end
          end
          default: state_o = state_i;
        endcase
      end else begin
        unique case (state_i.gesture) inside
          GestSlide:    state_o.gesture = GestSlideEnd;
          GestDown:     state_o.gesture = GestUp;
          GestSlideEnd: state_o.gesture = GestSlideEnd;
          default:      state_o.gesture = GestNone;
        endcase
      end
    end
  end

endmodule

// ===== design/touch_tap_slide_classifier.sv =====
// Top level of the touch tap and slide classifier with stream ports and config port.
// A poll accepted into the input register shows its result when the gesture
// state register, which also serves as the result register, loads from the input register.
// Throughput: one poll per cycle while the result side takes results or the slot is empty.
// Reset clears the gesture state, tracked positions, movement and valid flags, and loads
// the slide threshold with 6 and max_points with 5. No clearing pass is needed.
`include "touch_tap_slide_classifier_assert.svh"

module touch_tap_slide_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Poll stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata from bit 0: point_count[3:0], touch_x[14:0], touch_y[14:0], zero pad.
  input  logic [tts_pkg::DataInW-1:0]     s_axis_tdata,
  // tuser: report_ready.
  input  logic                            s_axis_tuser,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata from bit 0: pos_x, pos_y, origin_x, origin_y (15 bits each),
  // move_x, move_y (16 bits each), zero pad.
  output logic [tts_pkg::DataOutW-1:0]    m_axis_tdata,
  // tuser: event_code[2:0].
  output logic [2:0]                      m_axis_tuser,
  // Configuration writes.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tts_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tts_pkg::CfgDataW-1:0]    cfg_data_i
);
  import tts_pkg::*;

  tts_cfg_t   cfg_q;
  tts_item_t  in_q;
  logic       in_valid_q;
  tts_state_t state_q, state_d;
  logic       out_valid_q;
  logic       out_free;
  logic       advance;

  // The gesture state doubles as the result register: it only changes when a new
  // result is loaded, which needs the previous one taken or the slot empty.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slide_thresh <= SlideRangeRst;
      cfg_q.max_points   <= MaxPointsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSlideRange: cfg_q.slide_thresh <= cfg_data_i;
        CfgMaxPoints:  cfg_q.max_points   <= cfg_data_i[3:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  // Input register: holds one poll, so one more poll can be taken while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.ready <= s_axis_tuser;
      in_q.count <= s_axis_tdata[CountW-1:0];
      in_q.x     <= s_axis_tdata[XLsb +: CoordWidth];
      in_q.y     <= s_axis_tdata[YLsb +: CoordWidth];
    end
  end

  tts_step u_step (
    .state_i (state_q),
    .item_i  (in_q),
    .cfg_i   (cfg_q),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.gesture <= GestNone;
      state_q.cur_x   <= '0;
      state_q.cur_y   <= '0;
      state_q.begin_x <= '0;
      state_q.begin_y <= '0;
      state_q.diff_x  <= '0;
      state_q.diff_y  <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= advance;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = event_code(state_q.gesture);
  assign m_axis_tdata  = {4'b0000, state_q.diff_y, state_q.diff_x,
                          PortCoordW'(state_q.begin_y), PortCoordW'(state_q.begin_x),
                          PortCoordW'(state_q.cur_y), PortCoordW'(state_q.cur_x)};

  // A buffered poll is never dropped while the result side stalls.
  `TTS_ASSERT_NEXT(a_in_held, in_valid_q && !advance, in_valid_q)
  // Every processed poll produces a result in the next cycle.
  `TTS_ASSERT_NEXT(a_result_follows, advance, out_valid_q)
  // While pressed or just released without a slide, the tracked point is the origin.
  `TTS_ASSERT(a_tap_at_origin,
              !(state_q.gesture == GestDown || state_q.gesture == GestUp) ||
              (state_q.cur_x == state_q.begin_x && state_q.cur_y == state_q.begin_y))
  // A slide can only continue or end as a slide end.
  `TTS_ASSERT_NEXT(a_slide_exit, state_q.gesture == GestSlide,
                   state_q.gesture == GestSlide || state_q.gesture == GestSlideEnd)

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the touch tap and slide classifier.
module tb;
  import tts_pkg::*;

  // The slowest legal run stays far below this cycle limit. Each poll waits out a sender
  // gap, a receiver stall and its pass through the block, and there are two long hold-offs.
  localparam int unsigned CycleLimit = 400000;
  // Number of cycles the receiver refuses results during a hold-off.
  localparam int unsigned HoldCycles = 300;
  // Random polls offered in each configuration phase.
  localparam int unsigned PhasePolls = 235;

  typedef enum int unsigned {
    PaceFull,
    PaceSenderIdle,
    PaceReceiverStall,
    PaceBoth
  } pace_e;

  // One controller poll as the bench sees it.
  typedef struct {
    logic        ready;
    logic [3:0]  count;
    logic [14:0] x;
    logic [14:0] y;
  } poll_t;

  // One classifier report.
  typedef struct {
    logic [2:0]  ev;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic [14:0] org_x;
    logic [14:0] org_y;
    logic [15:0] mov_x;
    logic [15:0] mov_y;
  } report_t;

  // A row of the directed script. When typed is set, the report that follows is
  // spelled out in the row. Otherwise the gesture tracker below supplies it.
  typedef struct {
    logic        ready;
    logic [3:0]  count;
    logic [14:0] x;
    logic [14:0] y;
    bit          typed;
    logic [2:0]  ev;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic [14:0] org_x;
    logic [14:0] org_y;
    logic [15:0] mov_x;
    logic [15:0] mov_y;
  } script_row_t;

  // One configuration phase. When shuffle is set, the register values are drawn at random.
  typedef struct {
    logic [7:0] range_data;
    logic [7:0] points_data;
    bit         shuffle;
    pace_e      pace;
    bit         hold;
  } phase_t;

  // Ports of the block.
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DataInW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [DataOutW-1:0] m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Gesture tracker: the bench's own copy of the classifier state and registers.
  logic [2:0]  trk_event;
  logic [14:0] trk_cur_x, trk_cur_y;
  logic [14:0] trk_begin_x, trk_begin_y;
  logic [15:0] trk_move_x, trk_move_y;
  logic [7:0]  trk_slide_thresh;
  logic [3:0]  trk_max_points;

  // Reports still owed by the block, oldest first.
  report_t pending_reports[$];

  // Finger model used by the random part.
  int fing_x = 0;
  int fing_y = 0;
  int stroke_left = 0;

  int          err_count = 0;
  int          polls_sent = 0;
  int          reports_seen = 0;
  int          slides_seen = 0;
  int          phases_run = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req = 1'b0;
  longint      cycle_count = 0;

  // The directed script starts right after reset, with a slide threshold of 6 and
  // max_points 5.
  script_row_t script[24] = '{
    // A poll that is not ready after reset leaves everything at zero.
    '{0, 4'd3, 15'h7FFF, 15'h7FFF, 1, EvNone, 0, 0, 0, 0, 16'h0000, 16'h0000},
    // A ready poll with no points while idle stays idle.
    '{1, 4'd0, 15'h7FFF, 15'h0000, 1, EvNone, 0, 0, 0, 0, 16'h0000, 16'h0000},
    // The press at the origin corner.
    '{1, 4'd1, 15'h0000, 15'h0000, 1, EvDown, 0, 0, 0, 0, 16'h0000, 16'h0000},
    // A small movement is recorded, but the press does not move.
    '{1, 4'd5, 15'h0005, 15'h0000, 1, EvDown, 0, 0, 0, 0, 16'h0005, 16'h0000},
    // A movement of exactly the slide threshold in y starts a slide.
    '{1, 4'd5, 15'h0000, 15'h0006, 1, EvSlide, 0, 6, 0, 0, 16'h0000, 16'h0006},
    // The largest positive jump, then the largest negative jump.
    '{1, 4'd1, 15'h7FFF, 15'h7FFF, 1, EvSlide, 15'h7FFF, 15'h7FFF, 0, 0,
      16'h7FFF, 16'h7FF9},
    '{1, 4'd2, 15'h0000, 15'h0000, 1, EvSlide, 0, 0, 0, 0, 16'h8001, 16'h8001},
    // Too many points ends the slide, and further releases keep it ended.
    '{1, 4'd6, 15'h1234, 15'h4321, 1, EvSlideEnd, 0, 0, 0, 0, 16'h8001, 16'h8001},
    '{1, 4'd0, 15'h7FFF, 15'h7FFF, 1, EvSlideEnd, 0, 0, 0, 0, 16'h8001, 16'h8001},
    '{0, 4'd1, 15'h0055, 15'h0066, 1, EvSlideEnd, 0, 0, 0, 0, 16'h8001, 16'h8001},
    // A new press keeps the old movement values.
    '{1, 4'd3, 15'd100, 15'd200, 1, EvDown, 15'd100, 15'd200, 15'd100, 15'd200,
      16'h8001, 16'h8001},
    // A release from the press gives a tap, and the next release returns to idle.
    '{1, 4'd15, 15'h0000, 15'h0000, 1, EvUp, 15'd100, 15'd200, 15'd100, 15'd200,
      16'h8001, 16'h8001},
    '{1, 4'd0, 15'h0000, 15'h0000, 1, EvNone, 15'd100, 15'd200, 15'd100, 15'd200,
      16'h8001, 16'h8001},
    // The remaining rows are checked against the tracker.
    '{1, 4'd4, 15'h7FFF, 15'h0000, 0, EvNone, 0, 0, 0, 0, 0, 0},
    '{1, 4'd4, 15'h7FFA, 15'h0005, 0, EvNone, 0, 0, 0, 0, 0, 0},
    '{1, 4'd5, 15'h7FFF, 15'h0000, 0, EvNone, 0, 0, 0, 0, 0, 0},
    '{0, 4'd5, 15'h2AAA, 15'h5555, 0, EvNone, 0, 0, 0, 0, 0, 0},
    '{1, 4'd0, 15'h2AAA, 15'h5555, 0, EvNone, 0, 0, 0, 0, 0, 0},
    '{1, 4'd1, 15'h2AAA, 15'h5555, 0, EvNone, 0, 0, 0, 0, 0, 0},
    '{1, 4'd3, 15'h2AA4, 15'h5555, 0, EvNone, 0, 0, 0, 0, 0, 0},
    '{1, 4'd2, 15'h2AA5, 15'h5556, 0, EvNone, 0, 0, 0, 0, 0, 0},
    '{0, 4'd15, 15'h0000, 15'h0000, 0, EvNone, 0, 0, 0, 0, 0, 0},
    '{1, 4'd15, 15'h1111, 15'h2222, 0, EvNone, 0, 0, 0, 0, 0, 0},
    '{1, 4'd5, 15'h7FFF, 15'h7FFF, 0, EvNone, 0, 0, 0, 0, 0, 0}
  };

  // Register settings for the random part. The first phases pin the extremes, and the
  // later ones draw small slide ranges so that taps and slides both show up often. The
  // upper nibble of a max_points write is junk and must be ignored.
  phase_t phases[8] = '{
    '{8'd0,   8'hFF, 0, PaceFull,          1},
    '{8'd255, 8'h01, 0, PaceSenderIdle,    0},
    '{8'd3,   8'hA7, 0, PaceReceiverStall, 0},
    '{8'd1,   8'hF0, 0, PaceBoth,          0},
    '{8'd12,  8'h0F, 0, PaceFull,          1},
    '{8'd0,   8'h00, 1, PaceSenderIdle,    0},
    '{8'd0,   8'h00, 1, PaceReceiverStall, 0},
    '{8'd0,   8'h00, 1, PaceBoth,          0}
  };

  touch_tap_slide_classifier uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog. It ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("touch_tap_slide_classifier verification failed");
      $finish;
    end
  end

  // Puts the tracker in its post-reset state.
  task automatic reset_tracker();
    trk_event        = EvNone;
    trk_cur_x        = '0;
    trk_cur_y        = '0;
    trk_begin_x      = '0;
    trk_begin_y      = '0;
    trk_move_x       = '0;
    trk_move_y       = '0;
    trk_slide_thresh = SlideRangeRst;
    trk_max_points   = MaxPointsRst;
  endtask

  // Advances the tracker by one poll and returns the report the block must give.
  task automatic classify_poll(input poll_t p, output report_t r);
    int dx;
    int dy;
    int mag_x;
    int mag_y;
    if (p.ready) begin
      if (p.count != 0 && p.count <= trk_max_points) begin
        if (trk_event == EvNone || trk_event == EvUp || trk_event == EvSlideEnd) begin
          // A fresh press latches both the origin and the tracked position.
          trk_event   = EvDown;
          trk_cur_x   = p.x;
          trk_cur_y   = p.y;
          trk_begin_x = p.x;
          trk_begin_y = p.y;
        end else begin
          dx = int'(p.x) - int'(trk_cur_x);
          dy = int'(p.y) - int'(trk_cur_y);
          trk_move_x = dx[15:0];
          trk_move_y = dy[15:0];
          mag_x = (dx < 0) ? -dx : dx;
          mag_y = (dy < 0) ? -dy : dy;
          // A slide follows the finger. A press moves only once the threshold is met.
          if (trk_event == EvSlide || mag_x >= int'(trk_slide_thresh) ||
              mag_y >= int'(trk_slide_thresh)) begin
            trk_event = EvSlide;
            trk_cur_x = p.x;
            trk_cur_y = p.y;
          end
        end
      end else begin
        // No valid points: the finger has lifted.
        if (trk_event == EvSlide) begin
          trk_event = EvSlideEnd;
        end else if (trk_event == EvDown) begin
          trk_event = EvUp;
        end else if (trk_event != EvSlideEnd) begin
          trk_event = EvNone;
        end
      end
    end
    r.ev    = trk_event;
    r.pos_x = trk_cur_x;
    r.pos_y = trk_cur_y;
    r.org_x = trk_begin_x;
    r.org_y = trk_begin_y;
    r.mov_x = trk_move_x;
    r.mov_y = trk_move_y;
  endtask

  // Offers one poll, starting at a falling edge, and returns at the falling edge after
  // the transaction. When typed is set, the given report is expected in place of the
  // tracker's report. The tracker still advances in step.
  task automatic offer_poll(input poll_t p, input bit typed, input report_t typed_want);
    report_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = p.ready;
    s_axis_tdata  = {6'd0, p.y, p.x, p.count};
    do @(posedge clk_i); while (!s_axis_tready);
    classify_poll(p, want);
    pending_reports.push_back(typed ? typed_want : want);
    polls_sent++;
    @(negedge clk_i);
  endtask

  // Writes one register, starting at a falling edge, while the block is idle.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgSlideRange) begin
      trk_slide_thresh = data;
    end else if (idx == CfgMaxPoints) begin
      trk_max_points = data[3:0];
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Starting point of a stroke. Screen corners and borders get a fair share.
  function automatic int pick_coord();
    int unsigned sel;
    sel = $urandom_range(3);
    if (sel == 0) return 0;
    if (sel == 1) return 32767;
    return int'($urandom_range(32767));
  endfunction

  // Moves a finger coordinate by up to reach in either direction and keeps it on the panel.
  function automatic int walk(int pos, int reach);
    int v;
    v = pos + int'($urandom_range(2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  // Builds the next random poll. Most polls follow a finger through a stroke of a few
  // reports that ends in a release. The rest are not-ready polls and unrelated noise.
  task automatic next_poll(output poll_t p);
    int unsigned pick;
    int          reach;
    pick    = $urandom_range(99);
    p.ready = 1'b1;
    p.count = 4'd0;
    p.x     = 15'($urandom);
    p.y     = 15'($urandom);
    if (pick < 6) begin
      p.ready = 1'($urandom);
      p.count = 4'($urandom);
    end else if (pick < 12) begin
      p.ready = 1'b0;
      p.count = 4'($urandom);
    end else if (stroke_left == 0) begin
      // Release: either no points or more points than the block accepts.
      if (trk_max_points != 4'hF && $urandom_range(1) == 1) begin
        p.count = 4'($urandom_range(15, trk_max_points + 1));
      end
      stroke_left = $urandom_range(14, 1);
      fing_x      = pick_coord();
      fing_y      = pick_coord();
    end else begin
      stroke_left--;
      reach = 2 * int'(trk_slide_thresh) + 2;
      if ($urandom_range(7) == 0) begin
        fing_x = int'($urandom_range(32767));
        fing_y = int'($urandom_range(32767));
      end else begin
        fing_x = walk(fing_x, reach);
        fing_y = walk(fing_y, reach);
      end
      p.count = (trk_max_points == 0) ? 4'($urandom) :
                4'($urandom_range(trk_max_points, 1));
      p.x = 15'(fing_x);
      p.y = 15'(fing_y);
    end
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  // Result checker. Each result transaction is compared with the oldest report owed.
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("result with no poll waiting: event_code %0d", m_axis_tuser);
        err_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("event_code", 16'(want.ev), 16'(m_axis_tuser));
        check_field("pos_x", 16'(want.pos_x), 16'(m_axis_tdata[14:0]));
        check_field("pos_y", 16'(want.pos_y), 16'(m_axis_tdata[29:15]));
        check_field("origin_x", 16'(want.org_x), 16'(m_axis_tdata[44:30]));
        check_field("origin_y", 16'(want.org_y), 16'(m_axis_tdata[59:45]));
        check_field("move_x", want.mov_x, m_axis_tdata[75:60]);
        check_field("move_y", want.mov_y, m_axis_tdata[91:76]);
        if (m_axis_tuser == EvSlide) slides_seen++;
      end
    end
  end

  // Result sink. It stalls at random at the current rate. A rising hold_req makes it
  // refuse results for a long stretch, counted here, so that the block backs up onto its
  // input while the sender keeps offering.
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_seen;
    hold_left     = 0;
    hold_seen     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_seen) hold_left = HoldCycles;
      hold_seen = hold_req;
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin : stimulus
    poll_t   p;
    report_t typed_want;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgSlideRange;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    reset_tracker();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed script, run with light idling on both sides.
    tx_idle_pct  = 19;
    rx_stall_pct = 19;
    foreach (script[i]) begin
      p.ready          = script[i].ready;
      p.count          = script[i].count;
      p.x              = script[i].x;
      p.y              = script[i].y;
      typed_want.ev    = script[i].ev;
      typed_want.pos_x = script[i].pos_x;
      typed_want.pos_y = script[i].pos_y;
      typed_want.org_x = script[i].org_x;
      typed_want.org_y = script[i].org_y;
      typed_want.mov_x = script[i].mov_x;
      typed_want.mov_y = script[i].mov_y;
      offer_poll(p, script[i].typed, typed_want);
    end
    s_axis_tvalid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);

    // Random phases. Every report is drained before the registers change, which also
    // makes the sender pause until the block is empty.
    foreach (phases[k]) begin
      if (phases[k].shuffle) begin
        phases[k].range_data  = 8'($urandom_range(20));
        phases[k].points_data = {4'($urandom), 4'($urandom_range(15, 1))};
      end
      write_register(CfgSlideRange, phases[k].range_data);
      write_register(CfgMaxPoints, phases[k].points_data);
      case (phases[k].pace)
        PaceSenderIdle: begin
          tx_idle_pct  = 78;
          rx_stall_pct = 0;
        end
        PaceReceiverStall: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 78;
        end
        PaceBoth: begin
          tx_idle_pct  = 19;
          rx_stall_pct = 19;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      hold_req = phases[k].hold;
      repeat (PhasePolls) begin
        next_poll(p);
        offer_poll(p, 1'b0, typed_want);
      end
      s_axis_tvalid = 1'b0;
      hold_req      = 1'b0;
      while (pending_reports.size() != 0) @(negedge clk_i);
      phases_run++;
    end

    // Give a stray extra result time to show up.
    repeat (8) @(negedge clk_i);
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      err_count++;
    end
    $display("Run covered %0d polls over %0d register settings plus the directed script.",
             polls_sent, phases_run);
    $display("Checked %0d results, %0d of them slides; %0d mismatches.",
             reports_seen, slides_seen, err_count);
    if (err_count == 0) begin
      $display("touch_tap_slide_classifier verification clean");
    end else begin
      $display("touch_tap_slide_classifier verification failed");
    end
    $finish;
  end

endmodule

// ===== touch_tap_slide_classifier.f =====
+incdir+design
design/tts_pkg.sv
design/tts_step.sv
design/touch_tap_slide_classifier.sv
bench/tb.sv
